@@ hdl/gas_pkg.sv @@
// Shared types, constants and helper functions for the glyph atlas shelf allocator.
// Used by every module of the block; has no dependencies of its own.
package gas_pkg;

	localparam int unsigned DEF_MAX_PAGES     = 256;
	localparam int unsigned DEF_MAX_PAGE_SIDE = 512;
	localparam int unsigned SIDE_SCALE        = 20;

	localparam int unsigned SIDE_W   = 10;
	localparam int unsigned TARGET_W = 17;
	localparam int unsigned CX_W     = 11;
	localparam int unsigned CY_W     = 10;
	localparam int unsigned PAGES_W  = 9;
	localparam int unsigned CFG_W    = 12;

	typedef enum logic {
		CFG_MAX_GLYPH_WIDTH  = 1'b0,
		CFG_MAX_GLYPH_HEIGHT = 1'b1
	} cfg_index_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       glyph_type;
		logic [8:0] glyph_width;
	} in_word_t;

	typedef struct packed {
		logic [9:0] pos_x;
		logic [8:0] pos_y;
		logic [7:0] page_index;
		logic       opened_new_page;
		logic       atlas_full;
	} out_word_t;

	typedef struct packed {
		logic [SIDE_W-1:0] side;
		logic [8:0]        max_height;
	} cfg_t;

	// Smallest power of two from 2 upward that reaches the target, stopping at the cap.
	function automatic logic [SIDE_W-1:0] page_side(input logic [11:0] max_width,
		input logic [SIDE_W-1:0] cap);
		logic [TARGET_W-1:0] target;
		logic [SIDE_W:0]     s;
		target = TARGET_W'(max_width) * TARGET_W'(SIDE_SCALE);
		s = (SIDE_W+1)'(2);
		for (int k = 0; k < SIDE_W - 1; k++) begin
			if ((TARGET_W'(s) < target) && (s < {1'b0, cap})) begin
				s = s << 1;
			end
		end
		if (s > {1'b0, cap}) begin
			s = {1'b0, cap};
		end
		return s[SIDE_W-1:0];
	endfunction

endpackage

@@ hdl/gas_cfg.sv @@
// Configuration registers of the glyph atlas shelf allocator; derives the page side on write.
// Depends on gas_pkg.
module gas_cfg #(
	parameter int unsigned MAX_PAGE_SIDE = gas_pkg::DEF_MAX_PAGE_SIDE
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  gas_pkg::cfg_index_t        cfg_index,
	input  logic [gas_pkg::CFG_W-1:0]  cfg_wdata,
	output gas_pkg::cfg_t              cfg
);

	localparam logic [gas_pkg::SIDE_W-1:0] SIDE_CAP = gas_pkg::SIDE_W'(MAX_PAGE_SIDE);

	logic [gas_pkg::SIDE_W-1:0] side_q;
	logic [8:0]                 max_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q       <= gas_pkg::page_side(12'd0, SIDE_CAP);
			max_height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gas_pkg::CFG_MAX_GLYPH_WIDTH: begin
					side_q <= gas_pkg::page_side(cfg_wdata, SIDE_CAP);
				end
				gas_pkg::CFG_MAX_GLYPH_HEIGHT: begin
					max_height_q <= cfg_wdata[8:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.side       = side_q;
	assign cfg.max_height = max_height_q;

endmodule

@@ hdl/gas_core.sv @@
// Per-type cursor and page state of the shelf packer, with the placement logic for one word.
// Depends on gas_pkg.
module gas_core #(
	parameter int unsigned MAX_PAGES = gas_pkg::DEF_MAX_PAGES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gas_pkg::cfg_t     cfg,
	input  gas_pkg::in_word_t item,
	input  logic              fire,
	output gas_pkg::out_word_t result
);

	localparam logic [gas_pkg::PAGES_W-1:0] PAGE_LIMIT = gas_pkg::PAGES_W'(MAX_PAGES);

	logic [gas_pkg::CX_W-1:0]    cx_q [2];
	logic [gas_pkg::CY_W-1:0]    cy_q [2];
	logic [gas_pkg::PAGES_W-1:0] pages_q [2];

	logic [gas_pkg::CX_W-1:0]    cx;
	logic [gas_pkg::CY_W-1:0]    cy;
	logic [gas_pkg::PAGES_W-1:0] pages;
	logic [11:0]                 x_end;
	logic [11:0]                 y_end;
	logic [11:0]                 side_ext;
	logic                        need_row;
	logic                        need_page;
	logic                        full;
	logic                        new_page;
	logic [gas_pkg::CX_W-1:0]    cx_n;
	logic [gas_pkg::CY_W:0]      cy_n;
	logic [gas_pkg::PAGES_W-1:0] pages_n;
	logic [gas_pkg::PAGES_W-1:0] page_last;
	logic [11:0]                 cx_adv;

	assign cx       = cx_q[item.glyph_type];
	assign cy       = cy_q[item.glyph_type];
	assign pages    = pages_q[item.glyph_type];
	assign side_ext = 12'(cfg.side);

	// Right edge of the glyph in the current row, and bottom of a further row.
	assign x_end = 12'(cx) + 12'(item.glyph_width) + 12'd1;
	assign y_end = 12'(cy) + {2'b0, cfg.max_height, 1'b0} + 12'd2;

	assign need_row  = (pages == '0) || (x_end > side_ext);
	assign need_page = need_row && ((pages == '0) || (y_end > side_ext));
	assign full      = need_page && (pages >= PAGE_LIMIT);
	assign new_page  = need_page && !full;

	always_comb begin
		cx_n    = cx;
		cy_n    = {1'b0, cy};
		pages_n = pages;
		if (need_page) begin
			cx_n    = gas_pkg::CX_W'(1);
			cy_n    = (gas_pkg::CY_W+1)'(1);
			pages_n = pages + gas_pkg::PAGES_W'(1);
		end else if (need_row) begin
			cx_n = gas_pkg::CX_W'(1);
			cy_n = {1'b0, cy} + (gas_pkg::CY_W+1)'(cfg.max_height) + (gas_pkg::CY_W+1)'(1);
		end
	end

	assign page_last = pages_n - gas_pkg::PAGES_W'(1);
	assign cx_adv    = 12'(cx_n) + 12'(item.glyph_width) + 12'd1;

	always_comb begin
		if (full) begin
			result            = '0;
			result.atlas_full = 1'b1;
		end else begin
			result.pos_x           = cx_n[9:0];
			result.pos_y           = cy_n[8:0];
			result.page_index      = page_last[7:0];
			result.opened_new_page = new_page;
			result.atlas_full      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				cx_q[i]    <= gas_pkg::CX_W'(1);
				cy_q[i]    <= gas_pkg::CY_W'(1);
				pages_q[i] <= '0;
			end
		end else if (fire) begin
			unique case (item.op)
				gas_pkg::OP_CLEAR: begin
					for (int i = 0; i < 2; i++) begin
						cx_q[i]    <= gas_pkg::CX_W'(1);
						cy_q[i]    <= gas_pkg::CY_W'(1);
						pages_q[i] <= '0;
					end
				end
				gas_pkg::OP_ALLOC: begin
					if (!full) begin
						cx_q[item.glyph_type]    <= cx_adv[gas_pkg::CX_W-1:0];
						cy_q[item.glyph_type]    <= cy_n[gas_pkg::CY_W-1:0];
						pages_q[item.glyph_type] <= pages_n;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ hdl/glyph_atlas_shelf_allocator.sv @@
// Glyph atlas shelf allocator: out_valid rises as an allocate word moves from the input
// register to the output register. Throughput is one word per cycle unless out_ready stalls;
// a type's cursor state is updated at the edge where its word leaves the input register,
// so the next word sees it at once. Reset clears both cursors to (1,1), both page counts
// and the height register to zero, and sets page side 2 (zero width); no clearing pass is needed.
// Depends on gas_pkg, gas_cfg and gas_core.
module glyph_atlas_shelf_allocator #(
	parameter int unsigned MAX_PAGES     = gas_pkg::DEF_MAX_PAGES,
	parameter int unsigned MAX_PAGE_SIDE = gas_pkg::DEF_MAX_PAGE_SIDE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  gas_pkg::cfg_index_t       cfg_index,
	input  logic [gas_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  gas_pkg::in_word_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output gas_pkg::out_word_t        out_data
);

	gas_pkg::cfg_t      cfg;
	gas_pkg::in_word_t  item_s1;
	logic               valid_s1;
	gas_pkg::out_word_t result;
	gas_pkg::out_word_t out_data_q;
	logic               out_valid_q;
	logic               is_clear;
	logic               go_s1;
	logic               load_out;

	// The configuration registers hold the page side, already derived from the
	// maximum glyph width, so placement only compares and adds.
	gas_cfg #(
		.MAX_PAGE_SIDE(MAX_PAGE_SIDE)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	// A clear word never needs the output register, so it retires as soon as it
	// reaches the input register. An allocate word retires when the output
	// register is empty or is being drained in the same cycle.
	assign is_clear = (item_s1.op == gas_pkg::OP_CLEAR);
	assign go_s1    = valid_s1 && (is_clear || !out_valid_q || out_ready);
	assign load_out = go_s1 && !is_clear;
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Placement for the word in the input register; the state moves on go_s1.
	gas_core #(
		.MAX_PAGES(MAX_PAGES)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.item  (item_s1),
		.fire  (go_s1),
		.result(result)
	);

	// The output register separates the two sides, so a finished word can wait
	// for out_ready while the next word is already taken in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.atlas_full) |->
		(out_data.pos_x == '0 && out_data.pos_y == '0 && out_data.page_index == '0 &&
		 !out_data.opened_new_page))
		else $error("full result carries placement data");

	a_new_page_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.opened_new_page) |->
		(out_data.pos_x == 10'd1 && out_data.pos_y == 9'd1 && !out_data.atlas_full))
		else $error("new page not placed at its origin");

	a_clear_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && is_clear && !out_valid_q) |=> !out_valid_q)
		else $error("clear word produced a result");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty input register");
`endif

endmodule

@@ verif/gas_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the glyph atlas shelf allocator: watches both word channels and the
// register port, predicts each placement and compares it field by field.
// Depends on gas_pkg for the word, register index and operation types.
module gas_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  gas_pkg::cfg_index_t       cfg_index,
	input  logic [gas_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  gas_pkg::in_word_t         in_data,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  gas_pkg::out_word_t        out_data,
	output int                        placements_due,
	output int                        placements_checked,
	output int                        full_reports,
	output int                        fail_count
);

	localparam int unsigned PAGE_LIMIT = gas_pkg::DEF_MAX_PAGES;
	localparam int unsigned SIDE_CAP   = gas_pkg::DEF_MAX_PAGE_SIDE;

	logic [11:0]        width_limit;
	logic [8:0]         height_limit;
	logic [10:0]        col [2];
	logic [9:0]         row [2];
	logic [8:0]         pages [2];
	gas_pkg::out_word_t due_placements [$];
	gas_pkg::out_word_t oldest;

	// Page side: doubles from 2 until it covers twenty widest glyphs or hits the cap.
	function automatic int unsigned shelf_side(input logic [11:0] widest);
		int unsigned goal;
		int unsigned side;
		goal = 32'(widest) * 20;
		side = 2;
		while (side < goal && side < SIDE_CAP)
			side = side * 2;
		return (side > SIDE_CAP) ? SIDE_CAP : side;
	endfunction

	// Places one glyph of type t and advances that type's cursor, unless no page is left.
	function automatic gas_pkg::out_word_t place_glyph(input logic t, input logic [8:0] w);
		gas_pkg::out_word_t r;
		int unsigned        side;
		int unsigned        cx;
		int unsigned        cy;
		int unsigned        np;
		logic               fresh;
		side  = shelf_side(width_limit);
		cx    = col[t];
		cy    = row[t];
		np    = pages[t];
		fresh = 1'b0;
		r     = '0;
		if (np == 0 || cx + w + 1 > side) begin
			if (np == 0 || cy + 2 * height_limit + 2 > side) begin
				if (np >= PAGE_LIMIT) begin
					// No page left: report full and leave the cursor alone.
					r.atlas_full = 1'b1;
					return r;
				end
				np++;
				cx    = 1;
				cy    = 1;
				fresh = 1'b1;
			end else begin
				cx = 1;
				cy = cy + height_limit + 1;
			end
		end
		r.pos_x           = 10'(cx);
		r.pos_y           = 9'(cy);
		r.page_index      = 8'(np - 1);
		r.opened_new_page = fresh;
		col[t]            = 11'(cx + w + 1);
		row[t]            = 10'(cy);
		pages[t]          = 9'(np);
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [9:0] want,
		input logic [9:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s expected %0d got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_limit        = '0;
			height_limit       = '0;
			col                = '{11'd1, 11'd1};
			row                = '{10'd1, 10'd1};
			pages              = '{9'd0, 9'd0};
			due_placements.delete();
			placements_due     = 0;
			placements_checked = 0;
			full_reports       = 0;
			fail_count         = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == gas_pkg::CFG_MAX_GLYPH_WIDTH)
					width_limit = cfg_wdata[11:0];
				else
					height_limit = cfg_wdata[8:0];
			end
			if (out_valid && out_ready) begin
				if (due_placements.size() == 0) begin
					fail_count++;
					$display("%0t: placement %h arrived with none expected", $time, out_data);
				end else begin
					oldest = due_placements.pop_front();
					compare_field("pos_x", oldest.pos_x, out_data.pos_x);
					compare_field("pos_y", oldest.pos_y, out_data.pos_y);
					compare_field("page_index", oldest.page_index, out_data.page_index);
					compare_field("opened_new_page", oldest.opened_new_page,
						out_data.opened_new_page);
					compare_field("atlas_full", oldest.atlas_full, out_data.atlas_full);
					placements_checked++;
					if (oldest.atlas_full)
						full_reports++;
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.op == gas_pkg::OP_CLEAR) begin
					col   = '{11'd1, 11'd1};
					row   = '{10'd1, 10'd1};
					pages = '{9'd0, 9'd0};
				end else begin
					due_placements.push_back(place_glyph(in_data.glyph_type,
						in_data.glyph_width));
				end
			end
			placements_due = due_placements.size();
		end
	end

endmodule

@@ verif/tb_glyph_atlas_shelf_allocator.sv @@
`timescale 1ns / 100ps
// Top of the glyph atlas shelf allocator testbench: clock, reset, register writes and
// word traffic on both channels. Depends on gas_pkg, the block and gas_checker.
module tb_glyph_atlas_shelf_allocator;

	// The output side holds off this long once, while the input keeps offering words.
	localparam int unsigned HOLD_CYCLES = 64;
	// A clear answers nothing, so this many quiet cycles follow the last placement
	// before any register write.
	localparam int unsigned DRAIN_CYCLES = 4;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	gas_pkg::cfg_index_t       cfg_index;
	logic [gas_pkg::CFG_W-1:0] cfg_wdata;
	logic                      in_valid;
	logic                      in_ready;
	gas_pkg::in_word_t         in_data;
	logic                      out_valid;
	logic                      out_ready;
	gas_pkg::out_word_t        out_data;

	int placements_due;
	int placements_checked;
	int full_reports;
	int fail_count;

	// When calm is set neither side inserts random idle cycles.
	bit          calm;
	int          stall_requests;
	int          words_sent;
	int          reg_writes;
	logic [8:0]  width_cap;
	logic [11:0] phase_width [6];
	logic [8:0]  phase_height [6];

	glyph_atlas_shelf_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	gas_checker shelf_watch (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.in_data            (in_data),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.out_data           (out_data),
		.placements_due     (placements_due),
		.placements_checked (placements_checked),
		.full_reports       (full_reports),
		.fail_count         (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Absolute limit on the run; a correct run ends far sooner.
	initial begin
		#2000000;
		$display("FAIL glyph_atlas_shelf_allocator");
		$finish;
	end

	// Output side. It serves a pending hold-off request first, counting the stretch
	// itself, and otherwise takes words freely or with random idle cycles.
	initial begin
		int stalls_done;
		int held;
		out_ready   = 1'b0;
		stalls_done = 0;
		forever begin
			@(negedge clk);
			if (stalls_done != stall_requests) begin
				stalls_done++;
				out_ready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(negedge clk);
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 35);
			end
		end
	end

	function automatic gas_pkg::in_word_t alloc_word(input logic t, input logic [8:0] w);
		gas_pkg::in_word_t word;
		word.op          = gas_pkg::OP_ALLOC;
		word.glyph_type  = t;
		word.glyph_width = w;
		return word;
	endfunction

	// A clear carries random type and width bits, which the block must ignore.
	function automatic gas_pkg::in_word_t clear_word();
		gas_pkg::in_word_t word;
		word.op          = gas_pkg::OP_CLEAR;
		word.glyph_type  = 1'($urandom);
		word.glyph_width = 9'($urandom);
		return word;
	endfunction

	// Typical traffic: mostly glyphs no wider than the configured maximum, some of any
	// width, and now and then a clear.
	function automatic gas_pkg::in_word_t shelf_word();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 2)
			return clear_word();
		if (roll < 82)
			return alloc_word(1'($urandom), 9'($urandom_range(width_cap)));
		return alloc_word(1'($urandom), 9'($urandom));
	endfunction

	// Offers one word, with random idle cycles ahead of it unless calm, and returns
	// once it has been accepted. Valid stays high into the next word when there is no gap.
	task automatic push_word(input gas_pkg::in_word_t word);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= word;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	task automatic run_shelves(input int count);
		repeat (count)
			push_word(shelf_word());
	endtask

	// Lowers valid, waits for every expected placement and lets the pipe drain.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (placements_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_reg(input gas_pkg::cfg_index_t idx,
		input logic [gas_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	// New register values once the block is idle. The height write carries random bits
	// above the nine that the register keeps.
	task automatic configure(input logic [11:0] widest, input logic [8:0] tallest);
		settle();
		write_reg(gas_pkg::CFG_MAX_GLYPH_WIDTH, widest);
		write_reg(gas_pkg::CFG_MAX_GLYPH_HEIGHT, {3'($urandom), tallest});
		width_cap = (widest > 511) ? 9'd511 : widest[8:0];
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = gas_pkg::CFG_MAX_GLYPH_WIDTH;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		in_data        = '0;
		calm           = 1'b0;
		stall_requests = 0;
		words_sent     = 0;
		reg_writes     = 0;
		width_cap      = '0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Registers at reset give a page side of two, so every placement wants a page of
		// its own. Both extremes of width, both glyph types, and a clear in between.
		push_word(alloc_word(1'b0, 9'd0));
		push_word(alloc_word(1'b0, 9'd511));
		push_word(alloc_word(1'b1, 9'd0));
		push_word(clear_word());
		push_word(alloc_word(1'b1, 9'd511));

		// Largest register values: the page side stops at its cap and a row is as tall
		// as the page, so leaving a row always means a new page.
		configure(12'd4095, 9'd511);
		push_word(alloc_word(1'b0, 9'd511));
		push_word(alloc_word(1'b0, 9'd0));
		push_word(alloc_word(1'b1, 9'd100));
		push_word(alloc_word(1'b1, 9'd100));

		// Sixty-four pixel pages with eight pixel rows: three glyphs per row, so eight of
		// them fill two rows and part of a third. Then a glyph wider than the
		// page, which still lands in column one and pushes the next one to a new row.
		configure(12'd3, 9'd7);
		repeat (8)
			push_word(alloc_word(1'b0, 9'd20));
		push_word(alloc_word(1'b1, 9'd100));
		push_word(alloc_word(1'b1, 9'd5));
		push_word(clear_word());
		push_word(alloc_word(1'b0, 9'd0));

		// Page side two again: three hundred placements of one type use up every page,
		// after which the block must report the atlas full. Then both types recover.
		configure(12'd0, 9'd0);
		push_word(clear_word());
		repeat (300)
			push_word(alloc_word(1'b0, 9'($urandom)));
		run_shelves(20);
		push_word(clear_word());
		run_shelves(10);

		// Random phases over a spread of page sizes and row pitches, the extremes among
		// them. The fourth phase runs with no idle cycles on either side and, at its
		// start, a long output hold-off so the block fills and stalls its input.
		phase_width  = '{12'd25, 12'd4095, 12'd1, 12'd12,
			12'($urandom_range(40)), 12'($urandom_range(4095))};
		phase_height = '{9'd0, 9'd511, 9'd3, 9'd20,
			9'($urandom_range(60)), 9'($urandom_range(511))};
		for (int p = 0; p < 6; p++) begin
			configure(phase_width[p], phase_height[p]);
			calm = (p == 3);
			if (p == 3)
				stall_requests++;
			run_shelves(120);
		end
		calm = 1'b0;

		settle();
		$display("Sent %0d words over %0d register writes, with one long output hold-off.",
			words_sent, reg_writes);
		$display("Checked %0d placements, %0d of them reporting a full atlas.",
			placements_checked, full_reports);
		if (fail_count == 0)
			$display("PASS glyph_atlas_shelf_allocator");
		else
			$display("FAIL glyph_atlas_shelf_allocator");
		$finish;
	end

endmodule
